FILE: rtl/core/dep_pkg.sv
`timescale 1ns / 1ps

package dep_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TAG_W    = ADDR_W;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_INSERT  = 2'd1,
        MODE_DEL_MAX = 2'd2,
        MODE_DEL_MIN = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] key_value;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] removed_key;
        logic               queue_empty;
        logic signed [31:0] max_key;
        logic signed [31:0] min_key;
    } t_out_word;

    // One heap slot: the key and the insertion number it was tagged with.
    typedef struct packed {
        logic signed [31:0] key;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic               clear;
        t_entry             item;
    } t_heap_cmd;

    typedef struct packed {
        logic               busy;
        logic [CNT_W-1:0]   count;
        t_entry             top;
    } t_heap_stat;

    // True when key a must sit strictly above key b in the heap.
    function automatic logic f_above(input logic is_max, input logic signed [31:0] a,
                                     input logic signed [31:0] b);
        return is_max ? (a > b) : (a < b);
    endfunction

endpackage

FILE: rtl/core/dep_ram.sv
`timescale 1ns / 1ps

module dep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/dep_heap.sv
`timescale 1ns / 1ps

// Binary heap over one RAM. Sifts move a hole instead of swapping, which
// leaves the same layout as pairwise swaps.
module dep_heap import dep_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_is_max,
    input  t_heap_cmd  i_cmd,
    output t_heap_stat o_stat
);

    typedef enum logic [2:0] {
        H_IDLE, H_UP_CHK, H_UP_CMP, H_DN_LAST, H_DN_CHK, H_DN_L, H_DN_R
    } t_hstate;

    t_hstate          r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_pos, n_pos;
    t_entry           r_item, n_item;
    t_entry           r_left, n_left;
    t_entry           r_top;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_entry            w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    t_entry            w_rdata;
    logic [CNT_W:0]    w_two;
    logic [CNT_W:0]    w_cnt_x;
    t_entry            w_best;
    logic [CNT_W:0]    w_child;

    dep_ram #(.WIDTH($bits(t_entry)), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_two   = {r_pos, 1'b0};
        w_cnt_x = {1'b0, r_cnt};
        if (r_state == H_DN_R && f_above(i_is_max, w_rdata.key, r_left.key)) begin
            w_best  = w_rdata;
            w_child = w_two + (CNT_W + 1)'(1);
        end else if (r_state == H_DN_R) begin
            w_best  = r_left;
            w_child = w_two;
        end else begin
            w_best  = w_rdata;
            w_child = w_two;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_item  = r_item;
        n_left  = r_left;
        w_we    = 1'b0;
        w_waddr = ADDR_W'(r_pos - CNT_W'(1));
        w_wdata = r_item;
        w_raddr = '0;
        unique case (r_state)
            H_IDLE: begin
                if (i_cmd.clear) begin
                    n_cnt = '0;
                end else if (i_cmd.push) begin
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_pos   = r_cnt + CNT_W'(1);
                    n_item  = i_cmd.item;
                    n_state = H_UP_CHK;
                end else if (i_cmd.pop && r_cnt != '0) begin
                    w_raddr = ADDR_W'(r_cnt - CNT_W'(1));
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = H_DN_LAST;
                end
            end
            H_UP_CHK: begin
                if (r_pos == CNT_W'(1)) begin
                    w_we    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    w_raddr = ADDR_W'((r_pos >> 1) - CNT_W'(1));
                    n_state = H_UP_CMP;
                end
            end
            H_UP_CMP: begin
                w_we = 1'b1;
                if (f_above(i_is_max, r_item.key, w_rdata.key)) begin
                    w_wdata = w_rdata;
                    n_pos   = r_pos >> 1;
                    n_state = H_UP_CHK;
                end else begin
                    n_state = H_IDLE;
                end
            end
            H_DN_LAST: begin
                n_item  = w_rdata;
                n_pos   = CNT_W'(1);
                n_state = (r_cnt == '0) ? H_IDLE : H_DN_CHK;
            end
            H_DN_CHK: begin
                if (w_two > w_cnt_x) begin
                    w_we    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    w_raddr = ADDR_W'(w_two - (CNT_W + 1)'(1));
                    n_state = H_DN_L;
                end
            end
            H_DN_L, H_DN_R: begin
                if (r_state == H_DN_L && w_two < w_cnt_x) begin
                    n_left  = w_rdata;
                    w_raddr = ADDR_W'(w_two);
                    n_state = H_DN_R;
                end else begin
                    w_we = 1'b1;
                    if (f_above(i_is_max, w_best.key, r_item.key)) begin
                        w_wdata = w_best;
                        n_pos   = CNT_W'(w_child);
                        n_state = H_DN_CHK;
                    end else begin
                        n_state = H_IDLE;
                    end
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_pos  <= n_pos;
        r_item <= n_item;
        r_left <= n_left;
        // Mirror of the root slot so the top is visible without a read.
        if (w_we && w_waddr == '0) begin
            r_top <= w_wdata;
        end
    end

    assign o_stat.busy  = (r_state != H_IDLE);
    assign o_stat.count = r_cnt;
    assign o_stat.top   = r_top;

endmodule

FILE: rtl/core/double_ended_priority_queue_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Word
// input     in         i_in_valid / o_in_ready     i_in_data  (t_in_word)
// output    out        o_out_valid / i_out_ready   o_out_data (t_out_word)
//
// One word is worked at a time. A clear or a delete on an empty queue goes
// straight to the output. An insert sifts up level by level and a delete sifts
// down, with two child reads and a write per level; both end with a final top
// check of both heaps. Each deleted entry skipped at a heap top costs one more
// pop.
// Reset is synchronous and active low and leaves both heaps empty; no clearing
// pass is needed. A new word is taken while the previous result waits on the
// output register; a stalled output holds the next result in its final state.
module double_ended_priority_queue_core import dep_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_PUSH, S_POP, S_PG_CHK, S_PG_RD, S_PG_POP, S_OUT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_ins_cnt;
    logic               r_side;      // Heap being purged: 0 max, 1 min.
    t_status            r_status;
    logic signed [31:0] r_removed;
    logic               r_out_valid;
    t_out_word          r_out_data;

    t_heap_cmd  w_cmd_max, w_cmd_min;
    t_heap_stat w_max, w_min, w_sel;
    t_heap_stat w_del;

    logic              w_map_we;
    logic [ADDR_W-1:0] w_map_waddr;
    logic              w_map_wdata;
    logic [ADDR_W-1:0] w_map_raddr;
    logic              w_map_rdata;

    logic w_accept;
    logic w_out_free;

    dep_heap u_max_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_is_max(1'b1),
        .i_cmd   (w_cmd_max),
        .o_stat  (w_max)
    );

    dep_heap u_min_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_is_max(1'b0),
        .i_cmd   (w_cmd_min),
        .o_stat  (w_min)
    );

    // Deletion map by insertion number. Each bit is zeroed when its number is
    // handed out, so only bits written since the last clear are ever read.
    dep_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_removed_map (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata)
    );

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_sel      = r_side ? w_min : w_max;
    assign w_del      = (i_in_data.mode == MODE_DEL_MIN) ? w_min : w_max;

    always_comb begin
        w_cmd_max        = '0;
        w_cmd_min        = '0;
        w_cmd_max.item   = '{key: i_in_data.key_value, tag: TAG_W'(r_ins_cnt)};
        w_cmd_min.item   = w_cmd_max.item;
        w_map_we         = 1'b0;
        w_map_waddr      = TAG_W'(r_ins_cnt);
        w_map_wdata      = 1'b0;
        w_map_raddr      = w_sel.top.tag;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.mode)
                        MODE_CLEAR: begin
                            w_cmd_max.clear = 1'b1;
                            w_cmd_min.clear = 1'b1;
                        end
                        MODE_INSERT: begin
                            if (r_ins_cnt != CNT_W'(CAPACITY)) begin
                                w_cmd_max.push = 1'b1;
                                w_cmd_min.push = 1'b1;
                                w_map_we       = 1'b1;
                            end
                        end
                        default: begin
                            // Tops are always live here, so a nonzero count
                            // means a live key sits at the top.
                            if (w_del.count != '0) begin
                                w_map_we    = 1'b1;
                                w_map_waddr = w_del.top.tag;
                                w_map_wdata = 1'b1;
                                if (i_in_data.mode == MODE_DEL_MIN) begin
                                    w_cmd_min.pop = 1'b1;
                                end else begin
                                    w_cmd_max.pop = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            S_PG_RD: begin
                if (w_map_rdata) begin
                    if (r_side) begin
                        w_cmd_min.pop = 1'b1;
                    end else begin
                        w_cmd_max.pop = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ins_cnt   <= '0;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_OUT a taken output word is replaced by the next one below.
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_status  <= STAT_DONE;
                        r_removed <= '0;
                        r_side    <= 1'b0;
                        case (i_in_data.mode)
                            MODE_CLEAR: begin
                                r_ins_cnt <= '0;
                                r_state   <= S_OUT;
                            end
                            MODE_INSERT: begin
                                if (r_ins_cnt == CNT_W'(CAPACITY)) begin
                                    r_status <= STAT_FULL;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_ins_cnt <= r_ins_cnt + CNT_W'(1);
                                    r_state   <= S_PUSH;
                                end
                            end
                            default: begin
                                if (w_del.count == '0) begin
                                    r_status <= STAT_EMPTY;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_removed <= w_del.top.key;
                                    r_state   <= S_POP;
                                end
                            end
                        endcase
                    end
                end
                S_PUSH, S_POP: begin
                    if (!w_max.busy && !w_min.busy) begin
                        r_state <= S_PG_CHK;
                    end
                end
                S_PG_CHK: begin
                    if (w_sel.count != '0) begin
                        r_state <= S_PG_RD;
                    end else if (!r_side) begin
                        r_side <= 1'b1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_PG_RD: begin
                    if (w_map_rdata) begin
                        r_state <= S_PG_POP;
                    end else if (!r_side) begin
                        r_side  <= 1'b1;
                        r_state <= S_PG_CHK;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_PG_POP: begin
                    if (!w_sel.busy) begin
                        r_state <= S_PG_CHK;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out_data.status      <= r_status;
                        r_out_data.removed_key <= r_removed;
                        if (w_max.count == '0 || w_min.count == '0) begin
                            r_out_data.queue_empty <= 1'b1;
                            r_out_data.max_key     <= '0;
                            r_out_data.min_key     <= '0;
                        end else begin
                            r_out_data.queue_empty <= 1'b0;
                            r_out_data.max_key     <= w_max.top.key;
                            r_out_data.min_key     <= w_min.top.key;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
